/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the date adder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside of reset.
`define ASSERT_ON_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* sv/dag_pkg.sv */
// ----------------------------------------------------------------------------
// dag_pkg
// Types, constants and calendar helpers shared by the date adder modules.
// ----------------------------------------------------------------------------
package dag_pkg;

   // Port field widths
   localparam int MONTH_W = 4;
   localparam int DAYF_W  = 5;
   localparam int YEAR_W  = 14;
   localparam int ADD_W   = 16;

   // Days of the add count that take part, and the last year
   localparam int ADD_WIDTH  = 16;
   localparam int YEAR_LIMIT = 9999;

   localparam logic [ADD_W-1:0] ADD_MASK = (ADD_WIDTH >= ADD_W) ? {ADD_W{1'b1}} :
                                           ADD_W'((64'd1 << ADD_WIDTH) - 64'd1);

   // Running day count: start day plus the full add count
   localparam int DAY_W = $clog2(32 + (1 << ADD_W));
   // Running year: holds the limit plus one
   localparam int YR_W  = ($clog2(YEAR_LIMIT + 2) > YEAR_W) ? $clog2(YEAR_LIMIT + 2) : YEAR_W;

   // Year modulo 400: quotient by reciprocal multiply, (year * 5243) >> 21,
   // exact for every 14-bit year, then one multiply and subtract
   localparam int R400_W       = 9;
   localparam int QUO_W        = 6;
   localparam int DIV400_SHIFT = 21;
   localparam int PROD_W       = DIV400_SHIFT + QUO_W;
   localparam logic [PROD_W-1:0] DIV400_MUL  = PROD_W'(5243);
   localparam logic [YEAR_W-1:0] CYCLE_YEARS = YEAR_W'(400);

   // Status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_INVALID  = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   // Month numbers
   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   localparam logic [DAYF_W-1:0] MONTH_LEN [13] = '{
      5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_REM,
      F_PUSH
   } dag_fstate_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_RUN,
      B_FIN,
      B_DONE
   } dag_bstate_type;

   // One classified item between front and back
   typedef struct packed {
      logic                 invalid;
      logic [MONTH_W-1:0]   month;
      logic [DAY_W-1:0]     day;
      logic [YR_W-1:0]      year;
      logic [R400_W-1:0]    r400;
      logic [MONTH_W-1:0]   today_month;
      logic [DAYF_W-1:0]    today_day;
      logic [YEAR_W-1:0]    today_year;
   } dag_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } dag_qstat_type;

   // Leap year from the year modulo 400
   function automatic logic is_leap(input logic [R400_W-1:0] r);
      return (r[1:0] == 2'd0) && (r != R400_W'(100)) && (r != R400_W'(200)) &&
             (r != R400_W'(300));
   endfunction

   // Length of a month; zero for a month code outside 1..12
   function automatic logic [DAYF_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                       input logic leap);
      logic [DAYF_W-1:0] d;
      if (m > MONTH_DEC) begin
         d = '0;
      end else begin
         d = MONTH_LEN[m];
      end
      if (m == MONTH_FEB && leap) begin
         d = d + DAYF_W'(1);
      end
      return d;
   endfunction

endpackage

/* sv/dag_front.sv */
// ----------------------------------------------------------------------------
// dag_front
// Accepts a request, reduces its year modulo 400 by reciprocal multiplication
// and checks the start date; pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module dag_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [dag_pkg::MONTH_W-1:0]  req_in_month,
   input  logic [dag_pkg::DAYF_W-1:0]   req_in_day,
   input  logic [dag_pkg::YEAR_W-1:0]   req_in_year,
   input  logic [dag_pkg::ADD_W-1:0]    req_days_to_add,
   input  logic [dag_pkg::MONTH_W-1:0]  req_today_month,
   input  logic [dag_pkg::DAYF_W-1:0]   req_today_day,
   input  logic [dag_pkg::YEAR_W-1:0]   req_today_year,
   input  dag_pkg::dag_qstat_type       q_stat,
   output logic                         q_push,
   output dag_pkg::dag_item_type        q_item
);

   dag_pkg::dag_fstate_type state_ff, state_in;

   logic [dag_pkg::MONTH_W-1:0] month_ff, month_in;
   logic [dag_pkg::DAYF_W-1:0]  day_ff, day_in;
   logic [dag_pkg::YEAR_W-1:0]  year_ff, year_in;
   logic [dag_pkg::ADD_W-1:0]   add_ff, add_in;
   logic [dag_pkg::MONTH_W-1:0] tm_ff, tm_in;
   logic [dag_pkg::DAYF_W-1:0]  td_ff, td_in;
   logic [dag_pkg::YEAR_W-1:0]  ty_ff, ty_in;
   logic [dag_pkg::YEAR_W-1:0]  rem_ff, rem_in;
   logic [dag_pkg::QUO_W-1:0]   quo_ff, quo_in;

   logic [dag_pkg::PROD_W-1:0]  prod;
   logic                        leap;
   logic [dag_pkg::DAYF_W-1:0]  dim;
   logic                        date_ok;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dag_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      month_ff <= month_in;
      day_ff   <= day_in;
      year_ff  <= year_in;
      add_ff   <= add_in;
      tm_ff    <= tm_in;
      td_ff    <= td_in;
      ty_ff    <= ty_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
   end

   // Classify the held start date
   always_comb begin
      prod    = dag_pkg::PROD_W'(year_ff) * dag_pkg::DIV400_MUL;
      leap    = dag_pkg::is_leap(rem_ff[dag_pkg::R400_W-1:0]);
      dim     = dag_pkg::days_in_month(month_ff, leap);
      date_ok = (year_ff != '0) && (32'(year_ff) <= dag_pkg::YEAR_LIMIT) &&
                (month_ff >= dag_pkg::MONTH_JAN) && (month_ff <= dag_pkg::MONTH_DEC) &&
                (day_ff != '0) && (day_ff <= dim);
   end

   // Next state and outputs
   always_comb begin
      state_in = state_ff;
      month_in = month_ff;
      day_in   = day_ff;
      year_in  = year_ff;
      add_in   = add_ff;
      tm_in    = tm_ff;
      td_in    = td_ff;
      ty_in    = ty_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      q_push   = 1'b0;
      req_stall = (state_ff != dag_pkg::F_IDLE);

      q_item.invalid     = !date_ok;
      q_item.month       = month_ff;
      q_item.day         = dag_pkg::DAY_W'(day_ff) +
                           dag_pkg::DAY_W'(add_ff & dag_pkg::ADD_MASK);
      q_item.year        = dag_pkg::YR_W'(year_ff);
      q_item.r400        = rem_ff[dag_pkg::R400_W-1:0];
      q_item.today_month = tm_ff;
      q_item.today_day   = td_ff;
      q_item.today_year  = ty_ff;

      case (state_ff)
         dag_pkg::F_IDLE: begin
            // take a transfer and start the modulo reduction
            if (req_valid) begin
               month_in = req_in_month;
               day_in   = req_in_day;
               year_in  = req_in_year;
               add_in   = req_days_to_add;
               tm_in    = req_today_month;
               td_in    = req_today_day;
               ty_in    = req_today_year;
               state_in = dag_pkg::F_DIV;
            end
         end
         dag_pkg::F_DIV: begin
            // register the year divided by 400
            quo_in   = prod[dag_pkg::PROD_W-1:dag_pkg::DIV400_SHIFT];
            state_in = dag_pkg::F_REM;
         end
         dag_pkg::F_REM: begin
            // remainder: year less the whole 400-year cycles
            rem_in   = year_ff - dag_pkg::YEAR_W'(quo_ff) * dag_pkg::CYCLE_YEARS;
            state_in = dag_pkg::F_PUSH;
         end
         dag_pkg::F_PUSH: begin
            // hold until the queue has room
            if (!q_stat.full) begin
               q_push   = 1'b1;
               state_in = dag_pkg::F_IDLE;
            end
         end
         default: begin
            state_in = dag_pkg::F_IDLE;
         end
      endcase
   end

endmodule

/* sv/dag_queue.sv */
// ----------------------------------------------------------------------------
// dag_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dag_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  dag_pkg::dag_item_type  push_item,
   input  logic                   pop,
   output dag_pkg::dag_item_type  head_item,
   output dag_pkg::dag_qstat_type stat
);

   dag_pkg::dag_item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Advance pointers on push and pop
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
      head_item  = entry_ff[rd_ptr_ff];
      stat.full  = (count_ff == 2'd2);
      stat.empty = (count_ff == 2'd0);
   end

   `ASSERT_ON_CLK(a_count_range, count_ff != 2'd3, "queue count out of range")
   `ASSERT_ON_CLK(a_no_overflow, push |-> (count_ff != 2'd2) || pop, "push into full queue")
   `ASSERT_ON_CLK(a_no_underflow, pop |-> count_ff != 2'd0, "pop from empty queue")

endmodule

/* sv/dag_back.sv */
// ----------------------------------------------------------------------------
// dag_back
// Steps a classified date forward one month or one whole year per cycle,
// saturates on year overflow, compares with today and holds the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dag_back (
   input  logic                         clock,
   input  logic                         reset,
   input  dag_pkg::dag_qstat_type       q_stat,
   input  dag_pkg::dag_item_type        q_item,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic [dag_pkg::MONTH_W-1:0]  rsp_out_month,
   output logic [dag_pkg::DAYF_W-1:0]   rsp_out_day,
   output logic [dag_pkg::YEAR_W-1:0]   rsp_out_year,
   output logic                         rsp_is_past
);

   dag_pkg::dag_bstate_type state_ff, state_in;

   logic [dag_pkg::MONTH_W-1:0] month_ff, month_in;
   logic [dag_pkg::DAY_W-1:0]   day_ff, day_in;
   logic [dag_pkg::YR_W-1:0]    year_ff, year_in;
   logic [dag_pkg::R400_W-1:0]  r400_ff, r400_in;
   logic [dag_pkg::MONTH_W-1:0] tm_ff, tm_in;
   logic [dag_pkg::DAYF_W-1:0]  td_ff, td_in;
   logic [dag_pkg::YEAR_W-1:0]  ty_ff, ty_in;
   logic [1:0]                  status_ff, status_in;
   logic [dag_pkg::MONTH_W-1:0] out_month_ff, out_month_in;
   logic [dag_pkg::DAYF_W-1:0]  out_day_ff, out_day_in;
   logic [dag_pkg::YEAR_W-1:0]  out_year_ff, out_year_in;
   logic                        past_ff, past_in;

   logic                        leap_now;
   logic [dag_pkg::DAYF_W-1:0]  dim;
   logic [dag_pkg::DAY_W-1:0]   ylen;
   logic [dag_pkg::YR_W-1:0]    year_next;
   logic [dag_pkg::R400_W-1:0]  r400_next;
   logic                        year_step;
   logic                        past;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dag_pkg::B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Working and result registers
   always_ff @(posedge clock) begin
      month_ff     <= month_in;
      day_ff       <= day_in;
      year_ff      <= year_in;
      r400_ff      <= r400_in;
      tm_ff        <= tm_in;
      td_ff        <= td_in;
      ty_ff        <= ty_in;
      status_ff    <= status_in;
      out_month_ff <= out_month_in;
      out_day_ff   <= out_day_in;
      out_year_ff  <= out_year_in;
      past_ff      <= past_in;
   end

   // Calendar facts of the current month and year
   always_comb begin
      leap_now  = dag_pkg::is_leap(r400_ff);
      dim       = dag_pkg::days_in_month(month_ff, leap_now);
      ylen      = leap_now ? dag_pkg::DAY_W'(366) : dag_pkg::DAY_W'(365);
      year_next = year_ff + dag_pkg::YR_W'(1);
      r400_next = (r400_ff == dag_pkg::R400_W'(399)) ? '0 : r400_ff + dag_pkg::R400_W'(1);
      // on or before today, compared year, then month, then day
      if (year_ff != dag_pkg::YR_W'(ty_ff)) begin
         past = (year_ff < dag_pkg::YR_W'(ty_ff));
      end else if (month_ff != tm_ff) begin
         past = (month_ff < tm_ff);
      end else begin
         past = (day_ff <= dag_pkg::DAY_W'(td_ff));
      end
   end

   // Next state and outputs
   always_comb begin
      state_in     = state_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      year_in      = year_ff;
      r400_in      = r400_ff;
      tm_in        = tm_ff;
      td_in        = td_ff;
      ty_in        = ty_ff;
      status_in    = status_ff;
      out_month_in = out_month_ff;
      out_day_in   = out_day_ff;
      out_year_in  = out_year_ff;
      past_in      = past_ff;
      q_pop        = 1'b0;
      year_step    = 1'b0;

      case (state_ff)
         dag_pkg::B_IDLE: begin
            // pull the next item from the queue
            if (!q_stat.empty) begin
               q_pop = 1'b1;
               if (q_item.invalid) begin
                  status_in    = dag_pkg::STATUS_INVALID;
                  out_month_in = '0;
                  out_day_in   = '0;
                  out_year_in  = '0;
                  past_in      = 1'b0;
                  state_in     = dag_pkg::B_DONE;
               end else begin
                  status_in = dag_pkg::STATUS_OK;
                  month_in  = q_item.month;
                  day_in    = q_item.day;
                  year_in   = q_item.year;
                  r400_in   = q_item.r400;
                  tm_in     = q_item.today_month;
                  td_in     = q_item.today_day;
                  ty_in     = q_item.today_year;
                  state_in  = dag_pkg::B_RUN;
               end
            end
         end
         dag_pkg::B_RUN: begin
            // advance a whole year from January, else one month
            if (day_ff > dag_pkg::DAY_W'(dim)) begin
               if (month_ff == dag_pkg::MONTH_JAN && day_ff > ylen) begin
                  day_in    = day_ff - ylen;
                  year_step = 1'b1;
               end else begin
                  day_in = day_ff - dag_pkg::DAY_W'(dim);
                  if (month_ff == dag_pkg::MONTH_DEC) begin
                     month_in  = dag_pkg::MONTH_JAN;
                     year_step = 1'b1;
                  end else begin
                     month_in = month_ff + dag_pkg::MONTH_W'(1);
                  end
               end
               if (year_step) begin
                  year_in = year_next;
                  r400_in = r400_next;
                  // saturate past the last year
                  if (32'(year_next) > dag_pkg::YEAR_LIMIT) begin
                     status_in = dag_pkg::STATUS_OVERFLOW;
                     year_in   = dag_pkg::YR_W'(dag_pkg::YEAR_LIMIT);
                     month_in  = dag_pkg::MONTH_DEC;
                     day_in    = dag_pkg::DAY_W'(31);
                     state_in  = dag_pkg::B_FIN;
                  end
               end
            end else begin
               state_in = dag_pkg::B_FIN;
            end
         end
         dag_pkg::B_FIN: begin
            // register the result and the comparison with today
            out_month_in = month_ff;
            out_day_in   = day_ff[dag_pkg::DAYF_W-1:0];
            out_year_in  = year_ff[dag_pkg::YEAR_W-1:0];
            past_in      = past;
            state_in     = dag_pkg::B_DONE;
         end
         dag_pkg::B_DONE: begin
            // hold the result until the transfer
            if (!rsp_stall) begin
               state_in = dag_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = dag_pkg::B_IDLE;
         end
      endcase
   end

   assign rsp_valid     = (state_ff == dag_pkg::B_DONE);
   assign rsp_status    = status_ff;
   assign rsp_out_month = out_month_ff;
   assign rsp_out_day   = out_day_ff;
   assign rsp_out_year  = out_year_ff;
   assign rsp_is_past   = past_ff;

   `ASSERT_ON_CLK(a_invalid_zero, (rsp_valid && rsp_status == dag_pkg::STATUS_INVALID) |->
      (rsp_out_month == '0 && rsp_out_day == '0 && rsp_out_year == '0 && !rsp_is_past),
      "invalid result carries a date")
   `ASSERT_ON_CLK(a_run_month, (state_ff == dag_pkg::B_RUN) |->
      (month_ff >= dag_pkg::MONTH_JAN && month_ff <= dag_pkg::MONTH_DEC),
      "month out of range while stepping")
   `ASSERT_ON_CLK(a_run_year, (state_ff == dag_pkg::B_RUN) |->
      (year_ff != '0 && 32'(year_ff) <= dag_pkg::YEAR_LIMIT),
      "year beyond limit while stepping")

endmodule

/* sv/gregorian_date_add_days.sv */
// ----------------------------------------------------------------------------
// gregorian_date_add_days
// Adds a day count to a Gregorian date and compares the result with today.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): start date, day count and today's date; a
//   transfer happens on a clock edge with req_valid high and req_stall low.
//   Response channel (rsp_*): status (0 ok, 1 invalid start date, 2 year
//   overflow, saturated to December 31 of the last year), result date and
//   is_past (result on or before today). One response per request, in order.
//   The front end captures each request, divides the year by 400, takes the
//   remainder and pushes the item into a two-entry queue, so it keeps
//   taking requests while the back end works.
//   The back end steps one month, or one whole year from January, per cycle,
//   and takes the next item from the queue only once its response has
//   transferred; an invalid start date skips the steps.
//   A stalled response holds in its output register; req_stall stays high
//   from each transfer until its item is pushed, longer if the queue is full.
//   Reset (synchronous, active high) empties the queue and idles both ends.
// ----------------------------------------------------------------------------
module gregorian_date_add_days (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [dag_pkg::MONTH_W-1:0]  req_in_month,
   input  logic [dag_pkg::DAYF_W-1:0]   req_in_day,
   input  logic [dag_pkg::YEAR_W-1:0]   req_in_year,
   input  logic [dag_pkg::ADD_W-1:0]    req_days_to_add,
   input  logic [dag_pkg::MONTH_W-1:0]  req_today_month,
   input  logic [dag_pkg::DAYF_W-1:0]   req_today_day,
   input  logic [dag_pkg::YEAR_W-1:0]   req_today_year,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic [dag_pkg::MONTH_W-1:0]  rsp_out_month,
   output logic [dag_pkg::DAYF_W-1:0]   rsp_out_day,
   output logic [dag_pkg::YEAR_W-1:0]   rsp_out_year,
   output logic                         rsp_is_past
);

   dag_pkg::dag_qstat_type q_stat;
   dag_pkg::dag_item_type  push_item;
   dag_pkg::dag_item_type  head_item;
   logic                   q_push;
   logic                   q_pop;

   // Accept and classify
   dag_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_month    (req_in_month),
      .req_in_day      (req_in_day),
      .req_in_year     (req_in_year),
      .req_days_to_add (req_days_to_add),
      .req_today_month (req_today_month),
      .req_today_day   (req_today_day),
      .req_today_year  (req_today_year),
      .q_stat          (q_stat),
      .q_push          (q_push),
      .q_item          (push_item)
   );

   // Decouple front and back
   dag_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .stat      (q_stat)
   );

   // Step the date and hold the response
   dag_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_stat        (q_stat),
      .q_item        (head_item),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_out_month (rsp_out_month),
      .rsp_out_day   (rsp_out_day),
      .rsp_out_year  (rsp_out_year),
      .rsp_is_past   (rsp_is_past)
   );

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for gregorian_date_add_days.
//
// Sends start dates, day counts and today's dates over the request channel
// and checks every response against a calendar predictor that works in
// plain integers. The predictor validates the date, walks the day count
// forward month by month (400 years or one year at a time from January),
// saturates on year overflow and compares the result with today. The
// request side goes quiet in random bursts and the response side stalls in
// random bursts; both run clean toward the end.
// ----------------------------------------------------------------------------
module tb;

   localparam int unsigned CYCLE_DAYS = 146097;
   localparam int unsigned DAYS_PER_MONTH [13] = '{
      0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
   };
   localparam int QUIET_TAIL = 30;
   localparam int RANDOM_ITEMS = 250;

   typedef struct packed {
      logic [dag_pkg::MONTH_W-1:0] in_month;
      logic [dag_pkg::DAYF_W-1:0]  in_day;
      logic [dag_pkg::YEAR_W-1:0]  in_year;
      logic [dag_pkg::ADD_W-1:0]   days_to_add;
      logic [dag_pkg::MONTH_W-1:0] today_month;
      logic [dag_pkg::DAYF_W-1:0]  today_day;
      logic [dag_pkg::YEAR_W-1:0]  today_year;
   } date_req_type;

   typedef struct packed {
      logic [1:0]                  status;
      logic [dag_pkg::MONTH_W-1:0] out_month;
      logic [dag_pkg::DAYF_W-1:0]  out_day;
      logic [dag_pkg::YEAR_W-1:0]  out_year;
      logic                        is_past;
   } date_rsp_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [dag_pkg::MONTH_W-1:0] req_in_month = '0;
   logic [dag_pkg::DAYF_W-1:0]  req_in_day = '0;
   logic [dag_pkg::YEAR_W-1:0]  req_in_year = '0;
   logic [dag_pkg::ADD_W-1:0]   req_days_to_add = '0;
   logic [dag_pkg::MONTH_W-1:0] req_today_month = '0;
   logic [dag_pkg::DAYF_W-1:0]  req_today_day = '0;
   logic [dag_pkg::YEAR_W-1:0]  req_today_year = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [1:0]                  rsp_status;
   logic [dag_pkg::MONTH_W-1:0] rsp_out_month;
   logic [dag_pkg::DAYF_W-1:0]  rsp_out_day;
   logic [dag_pkg::YEAR_W-1:0]  rsp_out_year;
   logic                        rsp_is_past;

   date_req_type pending_dates[$];
   date_rsp_type predicted_dates[$];
   int           total_dates = 0;
   int           received_dates = 0;
   int           error_count = 0;

   gregorian_date_add_days DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_month    (req_in_month),
      .req_in_day      (req_in_day),
      .req_in_year     (req_in_year),
      .req_days_to_add (req_days_to_add),
      .req_today_month (req_today_month),
      .req_today_day   (req_today_day),
      .req_today_year  (req_today_year),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_out_month   (rsp_out_month),
      .rsp_out_day     (rsp_out_day),
      .rsp_out_year    (rsp_out_year),
      .rsp_is_past     (rsp_is_past)
   );

   // Generate the clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- calendar

   function automatic bit leap_year(input int unsigned y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
   endfunction

   function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
      int unsigned n;
      n = (m <= dag_pkg::MONTH_DEC) ? DAYS_PER_MONTH[m] : 0;
      if (m == dag_pkg::MONTH_FEB && leap_year(y)) begin
         n++;
      end
      return n;
   endfunction

   function automatic int unsigned year_days(input int unsigned y);
      return leap_year(y) ? 366 : 365;
   endfunction

   // Work out the response that one request should produce
   function automatic date_rsp_type predict_sum_date(input date_req_type r);
      date_rsp_type res;
      int unsigned  m;
      int unsigned  y;
      int unsigned  day;
      bit           overflow;
      res = '0;
      m = r.in_month;
      y = r.in_year;
      day = r.in_day;
      overflow = 1'b0;
      if (y < 1 || y > dag_pkg::YEAR_LIMIT || m < dag_pkg::MONTH_JAN ||
          m > dag_pkg::MONTH_DEC || day < 1 || day > month_days(m, y)) begin
         res.status = dag_pkg::STATUS_INVALID;
         return res;
      end
      day = day + (r.days_to_add & dag_pkg::ADD_MASK);
      // Walk forward: 400 years or one year at a time from January, else a month
      while (day > month_days(m, y)) begin
         if (m == dag_pkg::MONTH_JAN && day > CYCLE_DAYS) begin
            day -= CYCLE_DAYS;
            y += 400;
         end else if (m == dag_pkg::MONTH_JAN && day > year_days(y)) begin
            day -= year_days(y);
            y++;
         end else begin
            day -= month_days(m, y);
            m++;
            if (m > dag_pkg::MONTH_DEC) begin
               m = dag_pkg::MONTH_JAN;
               y++;
            end
         end
         if (y > dag_pkg::YEAR_LIMIT) begin
            overflow = 1'b1;
            break;
         end
      end
      // Saturate to the last day of the last year
      if (overflow) begin
         y = dag_pkg::YEAR_LIMIT;
         m = dag_pkg::MONTH_DEC;
         day = 31;
         res.status = dag_pkg::STATUS_OVERFLOW;
      end else begin
         res.status = dag_pkg::STATUS_OK;
      end
      if (y != r.today_year) begin
         res.is_past = y < r.today_year;
      end else if (m != r.today_month) begin
         res.is_past = m < r.today_month;
      end else begin
         res.is_past = day <= r.today_day;
      end
      res.out_month = m[dag_pkg::MONTH_W-1:0];
      res.out_day = day[dag_pkg::DAYF_W-1:0];
      res.out_year = y[dag_pkg::YEAR_W-1:0];
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic date_req_type make_date_req(input int unsigned m, input int unsigned d,
                                                  input int unsigned y, input int unsigned add,
                                                  input int unsigned tm, input int unsigned td,
                                                  input int unsigned ty);
      date_req_type r;
      r.in_month = m[dag_pkg::MONTH_W-1:0];
      r.in_day = d[dag_pkg::DAYF_W-1:0];
      r.in_year = y[dag_pkg::YEAR_W-1:0];
      r.days_to_add = add[dag_pkg::ADD_W-1:0];
      r.today_month = tm[dag_pkg::MONTH_W-1:0];
      r.today_day = td[dag_pkg::DAYF_W-1:0];
      r.today_year = ty[dag_pkg::YEAR_W-1:0];
      return r;
   endfunction

   // Mostly valid dates with day counts of every size; some raw noise
   function automatic date_req_type random_date_req();
      date_req_type r;
      date_rsp_type guess;
      int unsigned  pick;
      int unsigned  m;
      int unsigned  y;
      int           td;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         case ($urandom_range(0, 3))
            0: y = $urandom_range(9800, dag_pkg::YEAR_LIMIT);
            1: y = $urandom_range(1, 99) * 100 + $urandom_range(0, 4);
            2: y = $urandom_range(1, 50);
            default: y = $urandom_range(1, dag_pkg::YEAR_LIMIT);
         endcase
         m = $urandom_range(dag_pkg::MONTH_JAN, dag_pkg::MONTH_DEC);
         r.in_year = y[dag_pkg::YEAR_W-1:0];
         r.in_month = m[dag_pkg::MONTH_W-1:0];
         r.in_day = dag_pkg::DAYF_W'($urandom_range(1, month_days(m, y)));
      end else begin
         r.in_month = dag_pkg::MONTH_W'($urandom_range(0, 15));
         r.in_day = dag_pkg::DAYF_W'($urandom_range(0, 31));
         r.in_year = dag_pkg::YEAR_W'($urandom_range(0, 16383));
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3: r.days_to_add = dag_pkg::ADD_W'($urandom_range(0, 400));
         4, 5:       r.days_to_add = dag_pkg::ADD_W'($urandom_range(0, 3000));
         6, 7, 8:    r.days_to_add = dag_pkg::ADD_W'($urandom_range(0, 65535));
         default:    r.days_to_add = $urandom_range(0, 1) ? '1 : '0;
      endcase
      r.today_month = dag_pkg::MONTH_W'($urandom_range(1, 12));
      r.today_day = dag_pkg::DAYF_W'($urandom_range(1, 31));
      r.today_year = dag_pkg::YEAR_W'($urandom_range(1, dag_pkg::YEAR_LIMIT));
      // Aim today at the result, or one day to either side, to hit the tie
      guess = predict_sum_date(r);
      if (guess.status != dag_pkg::STATUS_INVALID && $urandom_range(0, 9) < 4) begin
         td = int'(guess.out_day) + $urandom_range(0, 2) - 1;
         if (td < 1) td = 1;
         if (td > 31) td = 31;
         r.today_year = guess.out_year;
         r.today_month = guess.out_month;
         r.today_day = dag_pkg::DAYF_W'(td);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- driver

   date_req_type cur_req;
   int           req_gap = 0;
   bit           req_bursty = 1'b1;

   // Present requests; hold the payload while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            predicted_dates.push_back(predict_sum_date(cur_req));
         end
         if ($urandom_range(0, 49) == 0) begin
            req_bursty = !req_bursty;
         end
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (req_bursty && pending_dates.size() > QUIET_TAIL &&
                      $urandom_range(0, 7) == 0) begin
            req_gap = $urandom_range(1, 19) - 1;
            req_valid <= 1'b0;
         end else if (pending_dates.size() > 0) begin
            cur_req = pending_dates.pop_front();
            req_in_month <= cur_req.in_month;
            req_in_day <= cur_req.in_day;
            req_in_year <= cur_req.in_year;
            req_days_to_add <= cur_req.days_to_add;
            req_today_month <= cur_req.today_month;
            req_today_day <= cur_req.today_day;
            req_today_year <= cur_req.today_year;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   int           rsp_hold = 0;
   bit           rsp_bursty = 1'b1;
   date_rsp_type want;

   // Check each response transfer and stall the response side in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            received_dates++;
            if (predicted_dates.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               want = predicted_dates.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_out_month !== want.out_month) begin
                  $error("out_month: expected %0d, actual %0d", want.out_month,
                         rsp_out_month);
                  error_count++;
               end
               if (rsp_out_day !== want.out_day) begin
                  $error("out_day: expected %0d, actual %0d", want.out_day, rsp_out_day);
                  error_count++;
               end
               if (rsp_out_year !== want.out_year) begin
                  $error("out_year: expected %0d, actual %0d", want.out_year,
                         rsp_out_year);
                  error_count++;
               end
               if (rsp_is_past !== want.is_past) begin
                  $error("is_past: expected %0d, actual %0d", want.is_past, rsp_is_past);
                  error_count++;
               end
            end
         end
         if ($urandom_range(0, 49) == 0) begin
            rsp_bursty = !rsp_bursty;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else if (rsp_bursty && received_dates + QUIET_TAIL < total_dates &&
                      $urandom_range(0, 7) == 0) begin
            rsp_hold = $urandom_range(1, 19) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      // Directed: field extremes, leap rules, rollovers, overflow, invalid dates
      pending_dates.push_back(make_date_req(1, 1, 1, 0, 1, 1, 1));
      pending_dates.push_back(make_date_req(12, 31, 9999, 0, 12, 31, 9999));
      pending_dates.push_back(make_date_req(12, 31, 9999, 1, 1, 1, 1));
      pending_dates.push_back(make_date_req(1, 1, 9999, 65535, 12, 31, 9999));
      pending_dates.push_back(make_date_req(1, 1, 1, 65535, 12, 31, 9999));
      pending_dates.push_back(make_date_req(2, 29, 2000, 0, 2, 29, 2000));
      pending_dates.push_back(make_date_req(2, 29, 1900, 5, 6, 15, 2020));
      pending_dates.push_back(make_date_req(2, 29, 2004, 365, 3, 1, 2005));
      pending_dates.push_back(make_date_req(2, 29, 2001, 1, 6, 15, 2020));
      pending_dates.push_back(make_date_req(2, 28, 1900, 1, 3, 1, 1900));
      pending_dates.push_back(make_date_req(2, 28, 2000, 1, 2, 28, 2000));
      pending_dates.push_back(make_date_req(12, 31, 1999, 1, 1, 1, 2000));
      pending_dates.push_back(make_date_req(1, 15, 2023, 366, 1, 16, 2024));
      pending_dates.push_back(make_date_req(0, 10, 2020, 3, 6, 15, 2020));
      pending_dates.push_back(make_date_req(13, 10, 2020, 3, 6, 15, 2020));
      pending_dates.push_back(make_date_req(15, 31, 16383, 65535, 12, 31, 9999));
      pending_dates.push_back(make_date_req(5, 0, 2020, 3, 6, 15, 2020));
      pending_dates.push_back(make_date_req(4, 31, 2020, 3, 6, 15, 2020));
      pending_dates.push_back(make_date_req(1, 31, 2020, 30, 3, 1, 2020));
      pending_dates.push_back(make_date_req(6, 1, 0, 3, 6, 15, 2020));
      pending_dates.push_back(make_date_req(6, 1, 10000, 3, 6, 15, 2020));
      pending_dates.push_back(make_date_req(3, 1, 9820, 65535, 1, 1, 9999));
      pending_dates.push_back(make_date_req(7, 4, 5000, 12345, 8, 31, 5033));
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pending_dates.push_back(random_date_req());
      end
      total_dates = pending_dates.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Drain: everything sent and every response back
      do begin
         @(negedge clock);
      end while (pending_dates.size() != 0 || req_valid || predicted_dates.size() != 0);
      repeat (300) @(negedge clock);

      if (error_count == 0) begin
         $display("gregorian_date_add_days test passed");
      end else begin
         $display("gregorian_date_add_days test failed");
      end
      $finish;
   end

   // Bound the run
   initial begin
      #4000000;
      $display("gregorian_date_add_days test failed");
      $finish;
   end

endmodule
